// File: hdl/eopg_pkg.sv
// Shared types, constants and the sine table generator of the elliptic orbit phase generator.
package eopg_pkg;

	// Angle units: 1/128 degree, one turn is 46080 units
	localparam int unsigned TURN_UNITS    = 46080;
	localparam int unsigned QUARTER_UNITS = 11520;

	// pi/2 in Q30, argument scale of the table series
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Field widths
	localparam int ANGLE_W  = 16;
	localparam int RADIUS_W = 16;
	localparam int POS_W    = 24;
	localparam int TRIG_W   = 15;   // table magnitude, Q1.15 without sign
	localparam int REM_W    = 14;   // remainder inside one quadrant
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Pipeline stages; the last one is the output register
	localparam int NUM_STAGES = 9;
	localparam int STG_LOAD   = 1;  // accumulators advanced, center picked
	localparam int STG_WRAP   = 2;  // angle reduced, cosine phase formed
	localparam int STG_QUAD   = 3;  // quadrant and remainder
	localparam int STG_SCALE  = 4;  // remainder scaled by table depth
	localparam int STG_RECIP  = 5;  // reciprocal multiply
	localparam int STG_ADDR   = 6;  // quotient correction, quadrant mirror
	localparam int STG_ROM    = 7;  // table read
	localparam int STG_MULT   = 8;  // radius times trig
	localparam int STG_OUT    = 9;  // round, add center, saturate

	typedef logic [ANGLE_W-1:0]          angle_t;
	typedef logic signed [POS_W-1:0]     pos_t;
	typedef logic [RADIUS_W-1:0]         radius_t;
	typedef logic signed [TRIG_W+1:0]    trig_t;
	typedef logic [NUM_STAGES:1]         stage_vec_t;

	localparam angle_t QUARTER_ANGLE = angle_t'(QUARTER_UNITS);
	localparam angle_t HALF_ANGLE    = angle_t'(2 * QUARTER_UNITS);
	localparam angle_t TRIPLE_ANGLE  = angle_t'(3 * QUARTER_UNITS);

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORBIT_STEP = 3'd0,
		REG_SPIN_STEP  = 3'd1,
		REG_RADIUS_A   = 3'd2,
		REG_RADIUS_B   = 3'd3,
		REG_CENTER_X   = 3'd4,
		REG_CENTER_Z   = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic use_given_center;
		pos_t given_center_x;
		pos_t given_center_z;
	} in_item_t;

	typedef struct packed {
		pos_t   pos_x;
		pos_t   pos_z;
		angle_t orbit_angle_out;
		angle_t spin_angle_out;
	} out_item_t;

	typedef struct packed {
		angle_t  orbit_step;
		angle_t  spin_step;
		radius_t radius_a;
		radius_t radius_b;
		pos_t    center_x;
		pos_t    center_z;
	} cfg_t;

	// Per-transaction data that rides along the pipeline
	typedef struct packed {
		angle_t orbit;
		angle_t spin;
		pos_t   cx;
		pos_t   cz;
	} side_t;

	// sin(x) for x in Q30 radians, Taylor series to x^17, rounded to Q15
	function automatic logic [TRIG_W-1:0] series_sine(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint unsigned q;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 72;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 110;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 156;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 210;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 272;
		sum  = sum + longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		q = (unsigned'(sum) + 64'd16384) >> 15;
		series_sine = (q > 64'd32767) ? 15'd32767 : q[TRIG_W-1:0];
	endfunction

endpackage

// File: hdl/eopg_phase.sv
// Orbit and spin phase accumulators, center select and angle wrap stages.
module eopg_phase (
	input  logic                  clk,
	input  logic                  arst_n,
	input  eopg_pkg::stage_vec_t  stage_en,
	input  logic                  accept,
	input  eopg_pkg::in_item_t    in_item,
	input  eopg_pkg::cfg_t        cfg,
	output eopg_pkg::side_t       side_s1,
	output eopg_pkg::angle_t      sin_angle_s2,
	output eopg_pkg::angle_t      cos_angle_s2
);

	localparam logic [16:0] TURN17    = 17'(eopg_pkg::TURN_UNITS);
	localparam logic [16:0] QUARTER17 = 17'(eopg_pkg::QUARTER_UNITS);

	eopg_pkg::angle_t orbit_q, spin_q;
	eopg_pkg::angle_t orbit_next, spin_next;
	logic [16:0]      orbit_sum, spin_sum, orbit_wrap, spin_wrap;
	logic [16:0]      cur17, red17, cos17, cos_wrap;

	// Phase add with a single wrap subtraction, low 16 bits kept
	always_comb begin
		orbit_sum  = {1'b0, orbit_q} + {1'b0, cfg.orbit_step};
		spin_sum   = {1'b0, spin_q} + {1'b0, cfg.spin_step};
		orbit_wrap = (orbit_sum >= TURN17) ? orbit_sum - TURN17 : orbit_sum;
		spin_wrap  = (spin_sum >= TURN17) ? spin_sum - TURN17 : spin_sum;
		orbit_next = orbit_wrap[15:0];
		spin_next  = spin_wrap[15:0];
	end

	// Accumulator state advances once per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orbit_q <= '0;
			spin_q  <= '0;
		end else if (accept) begin
			orbit_q <= orbit_next;
			spin_q  <= spin_next;
		end
	end

	// Stage 1: new angles and the chosen center
	always_ff @(posedge clk) begin
		if (stage_en[eopg_pkg::STG_LOAD]) begin
			side_s1.orbit <= orbit_next;
			side_s1.spin  <= spin_next;
			side_s1.cx    <= in_item.use_given_center ? in_item.given_center_x : cfg.center_x;
			side_s1.cz    <= in_item.use_given_center ? in_item.given_center_z : cfg.center_z;
		end
	end

	// Reduce below one turn; cosine is sine a quarter turn ahead
	always_comb begin
		cur17    = {1'b0, side_s1.orbit};
		red17    = (cur17 >= TURN17) ? cur17 - TURN17 : cur17;
		cos17    = red17 + QUARTER17;
		cos_wrap = (cos17 >= TURN17) ? cos17 - TURN17 : cos17;
	end

	// Stage 2
	always_ff @(posedge clk) begin
		if (stage_en[eopg_pkg::STG_WRAP]) begin
			sin_angle_s2 <= red17[15:0];
			cos_angle_s2 <= cos_wrap[15:0];
		end
	end

endmodule

// File: hdl/eopg_index.sv
// Angle to quarter-wave table address: quadrant split and division by a reciprocal.
module eopg_index #(
	parameter  int SINE_TABLE_DEPTH = 1024,
	localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
	input  logic                  clk,
	input  eopg_pkg::stage_vec_t  stage_en,
	input  eopg_pkg::angle_t      angle_s2,
	output logic [ADDR_W-1:0]     addr_s6,
	output logic                  neg_s6
);

	// index = (rem * DEPTH + quarter/2) / quarter; quarter = 45 * 256, so
	// drop 8 bits first, then divide by 45 with a reciprocal and one fix-up
	localparam int NUM_W       = $clog2(eopg_pkg::QUARTER_UNITS * (SINE_TABLE_DEPTH + 1));
	localparam int PRE_SHIFT   = 8;
	localparam int QUOT_DIV    = eopg_pkg::QUARTER_UNITS / (1 << PRE_SHIFT);
	localparam int M_W         = NUM_W - PRE_SHIFT;
	localparam int RECIP_SHIFT = M_W + $clog2(QUOT_DIV);
	localparam int PROD_W      = M_W + RECIP_SHIFT;
	localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / QUOT_DIV;

	logic [1:0]                quad_s3, quad_s4, quad_s5;
	logic [eopg_pkg::REM_W-1:0] rem_s3;
	logic [M_W-1:0]            m_s4, m_s5;
	logic [PROD_W-1:0]         prod_s5;

	logic [1:0]                quad;
	eopg_pkg::angle_t          base, diff;
	logic [NUM_W-1:0]          num;
	logic [ADDR_W-1:0]         q0, idx, addr;
	logic [M_W-1:0]            back, resid;

	// Quadrant by compare against the quarter boundaries
	always_comb begin
		if (angle_s2 >= eopg_pkg::TRIPLE_ANGLE) begin
			quad = 2'd3;
			base = eopg_pkg::TRIPLE_ANGLE;
		end else if (angle_s2 >= eopg_pkg::HALF_ANGLE) begin
			quad = 2'd2;
			base = eopg_pkg::HALF_ANGLE;
		end else if (angle_s2 >= eopg_pkg::QUARTER_ANGLE) begin
			quad = 2'd1;
			base = eopg_pkg::QUARTER_ANGLE;
		end else begin
			quad = 2'd0;
			base = '0;
		end
		diff = angle_s2 - base;
	end

	// Scaled numerator with round-half bias
	always_comb begin
		num = NUM_W'(rem_s3) * NUM_W'(SINE_TABLE_DEPTH) + NUM_W'(eopg_pkg::QUARTER_UNITS / 2);
	end

	// Reciprocal estimate is exact or one low; one compare corrects it
	always_comb begin
		q0    = prod_s5[RECIP_SHIFT +: ADDR_W];
		back  = M_W'(q0) * M_W'(QUOT_DIV);
		resid = m_s5 - back;
		idx   = (resid >= M_W'(QUOT_DIV)) ? q0 + ADDR_W'(1) : q0;
		addr  = quad_s5[0] ? ADDR_W'(SINE_TABLE_DEPTH) - idx : idx;
	end

	always_ff @(posedge clk) begin
		if (stage_en[eopg_pkg::STG_QUAD]) begin
			quad_s3 <= quad;
			rem_s3  <= diff[eopg_pkg::REM_W-1:0];
		end
		if (stage_en[eopg_pkg::STG_SCALE]) begin
			quad_s4 <= quad_s3;
			m_s4    <= num[NUM_W-1:PRE_SHIFT];
		end
		if (stage_en[eopg_pkg::STG_RECIP]) begin
			quad_s5 <= quad_s4;
			m_s5    <= m_s4;
			prod_s5 <= PROD_W'(m_s4) * PROD_W'(RECIP);
		end
		if (stage_en[eopg_pkg::STG_ADDR]) begin
			addr_s6 <= addr;
			neg_s6  <= quad_s5[1];
		end
	end

endmodule

// File: hdl/eopg_rom.sv
// Quarter-wave sine ROM in Q1.15 with two registered read ports and sign restore.
module eopg_rom #(
	parameter  int SINE_TABLE_DEPTH = 1024,
	localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
	input  logic                 clk,
	input  eopg_pkg::stage_vec_t stage_en,
	input  logic [ADDR_W-1:0]    addr_a,
	input  logic                 neg_a,
	input  logic [ADDR_W-1:0]    addr_b,
	input  logic                 neg_b,
	output eopg_pkg::trig_t      trig_a,
	output eopg_pkg::trig_t      trig_b
);

	logic [eopg_pkg::TRIG_W-1:0] rom [0:SINE_TABLE_DEPTH];
	logic [eopg_pkg::TRIG_W-1:0] mag_a_s7, mag_b_s7;
	logic                        neg_a_s7, neg_b_s7;
	eopg_pkg::trig_t             val_a, val_b;

	// Entry i holds sin(90 deg * i / depth), built at elaboration
	for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_rom
		localparam longint unsigned ARG = (eopg_pkg::HALF_PI_Q30 * longint'(i)) / SINE_TABLE_DEPTH;
		assign rom[i] = eopg_pkg::series_sine(ARG);
	end

	always_ff @(posedge clk) begin
		if (stage_en[eopg_pkg::STG_ROM]) begin
			mag_a_s7 <= rom[addr_a];
			mag_b_s7 <= rom[addr_b];
			neg_a_s7 <= neg_a;
			neg_b_s7 <= neg_b;
		end
	end

	// Second half of the turn gives the negative value
	always_comb begin
		val_a  = signed'({2'b00, mag_a_s7});
		val_b  = signed'({2'b00, mag_b_s7});
		trig_a = neg_a_s7 ? -val_a : val_a;
		trig_b = neg_b_s7 ? -val_b : val_b;
	end

endmodule

// File: hdl/eopg_place.sv
// One ellipse coordinate: radius times trig, rounded to Q.8, plus center, saturated.
module eopg_place (
	input  logic                 clk,
	input  eopg_pkg::stage_vec_t stage_en,
	input  eopg_pkg::radius_t    radius,
	input  eopg_pkg::trig_t      trig,
	input  eopg_pkg::pos_t       center_s8,
	output eopg_pkg::pos_t       pos_s9
);

	localparam int PROD_W   = eopg_pkg::RADIUS_W + eopg_pkg::TRIG_W + 3;
	localparam int SCALED_W = PROD_W - 15;
	localparam int SUM_W    = eopg_pkg::POS_W + 2;

	logic signed [PROD_W-1:0]   prod_s8;
	logic signed [PROD_W-1:0]   biased;
	logic signed [SCALED_W-1:0] scaled;
	logic signed [SUM_W-1:0]    sum;
	logic                       ovf;
	eopg_pkg::pos_t             pos;

	// Stage 8: Q8.8 radius times Q1.15 trig gives Q9.23
	always_ff @(posedge clk) begin
		if (stage_en[eopg_pkg::STG_MULT]) begin
			prod_s8 <= signed'({1'b0, radius}) * trig;
		end
	end

	// Round half up to Q.8, add center, clamp when the top bits disagree
	always_comb begin
		biased = prod_s8 + PROD_W'(16384);
		scaled = biased[PROD_W-1:15];
		sum    = {{(SUM_W - SCALED_W){scaled[SCALED_W-1]}}, scaled}
		       + {{(SUM_W - eopg_pkg::POS_W){center_s8[eopg_pkg::POS_W-1]}}, center_s8};
		ovf    = (sum[SUM_W-1:eopg_pkg::POS_W-1] != '0) && (sum[SUM_W-1:eopg_pkg::POS_W-1] != '1);
		if (ovf) begin
			pos = sum[SUM_W-1] ? {1'b1, {(eopg_pkg::POS_W - 1){1'b0}}}
			                   : {1'b0, {(eopg_pkg::POS_W - 1){1'b1}}};
		end else begin
			pos = sum[eopg_pkg::POS_W-1:0];
		end
	end

	// Stage 9: output register
	always_ff @(posedge clk) begin
		if (stage_en[eopg_pkg::STG_OUT]) begin
			pos_s9 <= pos;
		end
	end

endmodule

// File: hdl/elliptic_orbit_phase_generator_top.sv
// Top level of the elliptic orbit phase generator: config registers, pipeline control, datapath.
//
// Each accepted transaction advances the orbit and spin phase accumulators (1/128 degree
// units, one turn = 46080) and returns one result: the point (x, z) on the configured
// ellipse at the new orbit angle, plus both new angles. The datapath is a 9-stage pipeline
// that takes one transaction per clock while the output does not stall; its depth is set
// by the table address division (reciprocal multiply and correction), the sine ROM read
// and the radius multiply. Stages hold their data when the output stalls, and empty
// stages close up, so input keeps flowing until every stage is full. The sine table has
// SINE_TABLE_DEPTH+1 entries of 15 bits, read at two addresses at once (sine and cosine).
// Registers are written through cfg_wr_en with cfg_index 0..5 (orbit step, spin step,
// radius a, radius b, center x, center z); other indexes are ignored. Write configuration
// only while no transaction is in flight.
module elliptic_orbit_phase_generator_top #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  eopg_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output eopg_pkg::out_item_t                 out_data,
	input  logic                                cfg_wr_en,
	input  logic [eopg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [eopg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int NS     = eopg_pkg::NUM_STAGES;
	localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);

	eopg_pkg::cfg_t       cfg_q;
	eopg_pkg::stage_vec_t stage_vld_q;
	eopg_pkg::stage_vec_t stage_en;
	eopg_pkg::side_t      side_s1;
	eopg_pkg::side_t      side_q [2:NS];
	eopg_pkg::angle_t     sin_angle_s2, cos_angle_s2;
	logic [ADDR_W-1:0]    sin_addr_s6, cos_addr_s6;
	logic                 sin_neg_s6, cos_neg_s6;
	eopg_pkg::trig_t      sin_val, cos_val;
	eopg_pkg::pos_t       pos_x_s9, pos_z_s9;
	logic                 accept;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				eopg_pkg::REG_ORBIT_STEP: cfg_q.orbit_step <= cfg_wdata[eopg_pkg::ANGLE_W-1:0];
				eopg_pkg::REG_SPIN_STEP:  cfg_q.spin_step  <= cfg_wdata[eopg_pkg::ANGLE_W-1:0];
				eopg_pkg::REG_RADIUS_A:   cfg_q.radius_a   <= cfg_wdata[eopg_pkg::RADIUS_W-1:0];
				eopg_pkg::REG_RADIUS_B:   cfg_q.radius_b   <= cfg_wdata[eopg_pkg::RADIUS_W-1:0];
				eopg_pkg::REG_CENTER_X:   cfg_q.center_x   <= signed'(cfg_wdata[eopg_pkg::POS_W-1:0]);
				eopg_pkg::REG_CENTER_Z:   cfg_q.center_z   <= signed'(cfg_wdata[eopg_pkg::POS_W-1:0]);
				default: ;
			endcase
		end
	end

	// Stage enables: a stage loads when it is empty or its content moves on
	assign stage_en[NS] = !stage_vld_q[NS] || out_ready;
	for (genvar k = 1; k < NS; k++) begin : g_en
		assign stage_en[k] = !stage_vld_q[k] || stage_en[k+1];
	end

	assign in_ready = stage_en[eopg_pkg::STG_LOAD];
	assign accept   = in_valid && in_ready;

	// Valid bits per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q[1] <= 1'b0;
		end else if (stage_en[1]) begin
			stage_vld_q[1] <= in_valid;
		end
	end
	for (genvar k = 2; k <= NS; k++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stage_vld_q[k] <= 1'b0;
			end else if (stage_en[k]) begin
				stage_vld_q[k] <= stage_vld_q[k-1];
			end
		end
	end

	// Angles and center travel alongside the datapath
	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			side_q[2] <= side_s1;
		end
	end
	for (genvar k = 3; k <= NS; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (stage_en[k]) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	eopg_phase u_phase (
		.clk          (clk),
		.arst_n       (arst_n),
		.stage_en     (stage_en),
		.accept       (accept),
		.in_item      (in_data),
		.cfg          (cfg_q),
		.side_s1      (side_s1),
		.sin_angle_s2 (sin_angle_s2),
		.cos_angle_s2 (cos_angle_s2)
	);

	eopg_index #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_index_sin (
		.clk      (clk),
		.stage_en (stage_en),
		.angle_s2 (sin_angle_s2),
		.addr_s6  (sin_addr_s6),
		.neg_s6   (sin_neg_s6)
	);

	eopg_index #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_index_cos (
		.clk      (clk),
		.stage_en (stage_en),
		.angle_s2 (cos_angle_s2),
		.addr_s6  (cos_addr_s6),
		.neg_s6   (cos_neg_s6)
	);

	eopg_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom (
		.clk      (clk),
		.stage_en (stage_en),
		.addr_a   (cos_addr_s6),
		.neg_a    (cos_neg_s6),
		.addr_b   (sin_addr_s6),
		.neg_b    (sin_neg_s6),
		.trig_a   (cos_val),
		.trig_b   (sin_val)
	);

	eopg_place u_place_x (
		.clk       (clk),
		.stage_en  (stage_en),
		.radius    (cfg_q.radius_a),
		.trig      (cos_val),
		.center_s8 (side_q[eopg_pkg::STG_MULT].cx),
		.pos_s9    (pos_x_s9)
	);

	eopg_place u_place_z (
		.clk       (clk),
		.stage_en  (stage_en),
		.radius    (cfg_q.radius_b),
		.trig      (sin_val),
		.center_s8 (side_q[eopg_pkg::STG_MULT].cz),
		.pos_s9    (pos_z_s9)
	);

	// Result transaction
	assign out_valid                = stage_vld_q[NS];
	assign out_data.pos_x           = pos_x_s9;
	assign out_data.pos_z           = pos_z_s9;
	assign out_data.orbit_angle_out = side_q[NS].orbit;
	assign out_data.spin_angle_out  = side_q[NS].spin;

	// Any empty stage means the pipeline can take input
	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!(&stage_vld_q) |-> in_ready)
		else $error("pipeline has an empty stage but input is not ready");

	// An accepted transaction occupies the first stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> stage_vld_q[1])
		else $error("accepted transaction lost at the first stage");

	// A taken result with nothing behind it leaves the output empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !stage_vld_q[NS-1] |=> !out_valid)
		else $error("result repeated after it was taken");

endmodule
